### design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and codes for the json string unescape core
// Result record, decoder state record, decode modes, result kinds and error
// codes used by the decoder, the result queue and the top level.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // decode modes
  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_TEXT = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX  = 3'd3,
    MODE_DROP = 3'd4
  } mode_e;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_NOQUOTE = 3'd1;
  localparam logic [2:0] ERR_CTRL    = 3'd2;
  localparam logic [2:0] ERR_ESC     = 3'd3;
  localparam logic [2:0] ERR_HEX     = 3'd4;
  localparam logic [2:0] ERR_SURR    = 3'd5;
  localparam logic [2:0] ERR_FULL    = 3'd6;
  localparam logic [2:0] ERR_TRUNC   = 3'd7;

  // most results one input item can cause
  localparam int unsigned NUM_SLOTS = 4;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [2:0]  err;
    logic [15:0] len;
    logic        last;
  } result_t;

  // all results of one input item, slot 0 first
  typedef struct packed {
    result_t [NUM_SLOTS-1:0] res;
    logic    [2:0]           cnt;
  } bundle_t;

  // decoder state apart from the byte count
  typedef struct packed {
    mode_e       mode;
    logic [15:0] cp;
    logic [1:0]  hc;
  } dec_state_t;

endpackage

### design/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode: per-byte decode step
// Combinational next-state and result bundle for one raw byte: quote
// handling, escapes, \u hex collection, utf-8 encoding and capacity check.
// ----------------------------------------------------------------------------
module jsu_decode import jsu_pkg::*; #(
  parameter int unsigned CountWidth = 16
) (
  input  dec_state_t            state_i,
  input  logic [CountWidth-1:0] count_i,
  input  logic [15:0]           cap_i,
  input  logic [7:0]            byte_i,
  input  logic                  eoi_i,
  output dec_state_t            state_o,
  output logic [CountWidth-1:0] count_o,
  output bundle_t               bundle_o
);

  localparam int unsigned SumW = ((CountWidth > 16) ? CountWidth : 16) + 1;
  localparam logic [SumW-1:0] CapLimit = SumW'(1) << CountWidth;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;

  // hex digit: {valid, value}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  logic [4:0]      hex_r;
  logic [15:0]     cp_new;
  logic [7:0]      enc0, enc1, enc2;
  logic [1:0]      enc_cnt;
  logic            is_surr;
  logic [1:0]      need;
  logic [SumW-1:0] eff_cap;
  logic            room;
  logic            esc_ok;
  logic [7:0]      esc_val;
  logic [2:0]      err;
  logic            done;
  logic            drop;
  logic [2:0]      n;
  logic [2:0]      n_m1;

  // next code point and its utf-8 form
  assign hex_r  = hex_nibble(byte_i);
  assign cp_new = {state_i.cp[11:0], hex_r[3:0]};
  assign is_surr = (cp_new >= 16'hd800) && (cp_new <= 16'hdfff);

  always_comb begin
    enc0 = cp_new[7:0];
    enc1 = '0;
    enc2 = '0;
    enc_cnt = 2'd1;
    if (cp_new <= 16'h007f) begin
      enc_cnt = 2'd1;
    end else if (cp_new <= 16'h07ff) begin
      enc0 = 8'hc0 | {3'b0, cp_new[10:6]};
      enc1 = 8'h80 | {2'b0, cp_new[5:0]};
      enc_cnt = 2'd2;
    end else begin
      enc0 = 8'he0 | {4'b0, cp_new[15:12]};
      enc1 = 8'h80 | {2'b0, cp_new[11:6]};
      enc2 = 8'h80 | {2'b0, cp_new[5:0]};
      enc_cnt = 2'd3;
    end
  end

  // room check against capacity, terminator kept free
  always_comb begin
    eff_cap = SumW'(cap_i);
    if (CountWidth < 16 && eff_cap > CapLimit) begin
      eff_cap = CapLimit;
    end
  end

  assign need = (state_i.mode == MODE_HEX) ? enc_cnt : 2'd1;
  assign room = (SumW'(count_i) + SumW'(need)) < eff_cap;

  // escape letter map
  always_comb begin
    esc_ok  = 1'b1;
    esc_val = byte_i;
    case (byte_i)
      8'h22, 8'h5c, 8'h2f: esc_val = byte_i;
      8'h62:               esc_val = 8'h08;
      8'h66:               esc_val = 8'h0c;
      8'h6e:               esc_val = 8'h0a;
      8'h72:               esc_val = 8'h0d;
      8'h74:               esc_val = 8'h09;
      default:             esc_ok  = 1'b0;
    endcase
  end

  // main decode
  always_comb begin
    state_o  = state_i;
    count_o  = count_i;
    bundle_o = '0;
    err      = ERR_NONE;
    done     = 1'b0;
    drop     = 1'b0;
    n        = 3'd0;
    n_m1     = 3'd0;
    case (state_i.mode)
      MODE_IDLE: begin
        if (byte_i != CH_QUOTE) begin
          err = ERR_NOQUOTE;
        end else if (cap_i == 16'd0) begin
          err = ERR_FULL;
        end else begin
          state_o.mode = MODE_TEXT;
          count_o = '0;
        end
      end
      MODE_TEXT: begin
        if (byte_i == CH_QUOTE) begin
          bundle_o.res[0].kind = KIND_DONE;
          bundle_o.res[0].len  = 16'(count_i);
          n = 3'd1;
          done = 1'b1;
        end else if (byte_i < 8'h20) begin
          err = ERR_CTRL;
        end else if (byte_i == CH_BSL) begin
          state_o.mode = MODE_ESC;
        end else if (!room) begin
          err = ERR_FULL;
        end else begin
          bundle_o.res[0].kind = KIND_BYTE;
          bundle_o.res[0].data = byte_i;
          n = 3'd1;
          count_o = count_i + CountWidth'(1);
        end
      end
      MODE_ESC: begin
        if (byte_i == 8'h75) begin
          state_o.mode = MODE_HEX;
          state_o.cp   = '0;
          state_o.hc   = '0;
        end else if (!esc_ok) begin
          err = ERR_ESC;
        end else if (!room) begin
          err = ERR_FULL;
        end else begin
          bundle_o.res[0].kind = KIND_BYTE;
          bundle_o.res[0].data = esc_val;
          n = 3'd1;
          count_o = count_i + CountWidth'(1);
          state_o.mode = MODE_TEXT;
        end
      end
      MODE_HEX: begin
        if (!hex_r[4]) begin
          err = ERR_HEX;
        end else begin
          state_o.cp = cp_new;
          if (state_i.hc != 2'd3) begin
            state_o.hc = state_i.hc + 2'd1;
          end else begin
            state_o.hc = '0;
            if (is_surr) begin
              err = ERR_SURR;
            end else if (!room) begin
              err = ERR_FULL;
            end else begin
              bundle_o.res[0].kind = KIND_BYTE;
              bundle_o.res[0].data = enc0;
              bundle_o.res[1].kind = KIND_BYTE;
              bundle_o.res[1].data = enc1;
              bundle_o.res[2].kind = KIND_BYTE;
              bundle_o.res[2].data = enc2;
              n = {1'b0, enc_cnt};
              count_o = count_i + CountWidth'(enc_cnt);
              state_o.mode = MODE_TEXT;
            end
          end
        end
      end
      default: begin
        // dropping after an error
        drop = 1'b1;
        if (eoi_i) begin
          state_o.mode = MODE_IDLE;
        end
      end
    endcase

    // error, completion and truncation tail
    if (!drop) begin
      if (err != ERR_NONE) begin
        bundle_o.res[n[1:0]]      = '0;
        bundle_o.res[n[1:0]].kind = KIND_ERR;
        bundle_o.res[n[1:0]].err  = err;
        n = n + 3'd1;
        state_o.mode = eoi_i ? MODE_IDLE : MODE_DROP;
      end else if (done) begin
        state_o.mode = MODE_IDLE;
      end else if (eoi_i && state_o.mode != MODE_IDLE) begin
        bundle_o.res[n[1:0]]      = '0;
        bundle_o.res[n[1:0]].kind = KIND_ERR;
        bundle_o.res[n[1:0]].err  = ERR_TRUNC;
        n = n + 3'd1;
        state_o.mode = MODE_IDLE;
      end
      if (state_o.mode == MODE_IDLE) begin
        state_o.cp = '0;
        state_o.hc = '0;
      end
      if (n != 3'd0) begin
        n_m1 = n - 3'd1;
        bundle_o.res[n_m1[1:0]].last = 1'b1;
      end
    end
    bundle_o.cnt = n;
  end

endmodule

### design/jsu_out_queue.sv
// ----------------------------------------------------------------------------
// jsu_out_queue: result queue and output register
// Holds the results of one decoded item and hands them out one per cycle,
// head first while not stalled; takes a new bundle as its last item leaves.
// ----------------------------------------------------------------------------
module jsu_out_queue import jsu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  bundle_t     bundle_i,
  output logic        free_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // out_byte, error_code, string_length
  output logic [1:0]  m_axis_tuser,  // result_kind
  output logic        m_axis_tlast   // last_of_run
);

  result_t [NUM_SLOTS-1:0] res_q, res_d;
  logic [2:0]              count_q, count_d;
  logic                    take;

  assign take   = m_axis_tvalid && m_axis_tready;
  assign free_o = (count_q == 3'd0) || ((count_q == 3'd1) && take);

  // load a bundle or shift the head out
  always_comb begin
    res_d   = res_q;
    count_d = count_q;
    if (load_i) begin
      res_d   = bundle_i.res;
      count_d = bundle_i.cnt;
    end else if (take) begin
      res_d[0] = res_q[1];
      res_d[1] = res_q[2];
      res_d[2] = res_q[3];
      count_d  = count_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // head item on the bus
  assign m_axis_tvalid = (count_q != 3'd0);
  assign m_axis_tdata  = {5'b0, res_q[0].len, res_q[0].err, res_q[0].data};
  assign m_axis_tuser  = res_q[0].kind;
  assign m_axis_tlast  = res_q[0].last;

endmodule

### design/json_string_unescape_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_core: streaming decoder for one quoted json string
// Takes one raw byte per item and gives decoded bytes, a completion item with
// the length, or an error item; drops bytes after an error up to end of input.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | tdata[7:0] in_byte, tlast end_of_input
//  m_axis   | out       | tdata out_byte/error_code/string_length,
//           |           | tuser result_kind, tlast last_of_run
//  cfg      | in        | cfg_wr_data_i output_capacity, written on cfg_wr_en_i
//
//  one input item per cycle while the queue is free; items pass the input
//  register, then the result queue; an item causing n results (n <= 4) holds
//  the queue until all leave, lowering the rate to one result per cycle
//  an output stall holds the queue; once the input register holds an item the
//  queue cannot take, s_axis_tready drops in the same cycle as m_axis_tready
//  reset: idle awaiting an opening quote, capacity 128, queue empty
// ----------------------------------------------------------------------------
module json_string_unescape_core import jsu_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // in_byte
  input  logic        s_axis_tlast,  // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // out_byte, error_code, string_length
  output logic [1:0]  m_axis_tuser,  // result_kind
  output logic        m_axis_tlast   // last_of_run
);

  logic [15:0]            cap_q;
  logic                   in_vld_q;
  logic [7:0]             in_byte_q;
  logic                   in_eoi_q;
  dec_state_t             st_q, st_d;
  logic [COUNT_WIDTH-1:0] bc_q, bc_d;
  bundle_t                bundle;
  logic                   q_free;
  logic                   commit;
  logic                   load;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 16'd128;
    end else if (cfg_wr_en_i) begin
      cap_q <= cfg_wr_data_i;
    end
  end

  // input register
  assign commit        = in_vld_q && q_free;
  assign load          = commit && (bundle.cnt != 3'd0);
  assign s_axis_tready = !in_vld_q || commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_eoi_q  <= s_axis_tlast;
    end
  end

  // decode step
  jsu_decode #(
    .CountWidth(COUNT_WIDTH)
  ) u_decode (
    .state_i  (st_q),
    .count_i  (bc_q),
    .cap_i    (cap_q),
    .byte_i   (in_byte_q),
    .eoi_i    (in_eoi_q),
    .state_o  (st_d),
    .count_o  (bc_d),
    .bundle_o (bundle)
  );

  // decoder state, updated when an item is committed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{mode: MODE_IDLE, cp: '0, hc: '0};
      bc_q <= '0;
    end else if (commit) begin
      st_q <= st_d;
      bc_q <= bc_d;
    end
  end

  // result queue
  jsu_out_queue u_out_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .bundle_i      (bundle),
    .free_o        (q_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef NO_ASSERTIONS
  // decode mode stays within its defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.mode <= MODE_DROP)
    else $error("decode mode out of range");

  // dropped bytes give no results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && st_q.mode == MODE_DROP |-> bundle.cnt == 3'd0)
    else $error("result produced while dropping");

  // a bundle never overruns the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> bundle.cnt <= 3'd4)
    else $error("bundle larger than queue");

  // a loaded bundle shows up at the output in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> m_axis_tvalid)
    else $error("loaded bundle not presented");
`endif

endmodule
